// File: rtl/aes_pkg.sv
// Shared types, tables and helpers for the AES block encrypt pipeline.
package aes_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int RK_NUM     = MAX_ROUNDS + 1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  typedef enum logic [2:0] {
    REG_KEY_SIZE = 3'd0,
    REG_KEY_0    = 3'd1,
    REG_KEY_1    = 3'd2,
    REG_KEY_2    = 3'd3,
    REG_KEY_3    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_t;

  typedef enum logic [1:0] {
    EXP_LOAD,
    EXP_RUN,
    EXP_IDLE
  } exp_state_t;

  // Control handed along the round chain.
  typedef struct packed {
    logic valid;
    logic last;
  } cell_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant by word index / Nk.
  function automatic logic [7:0] rcon(input logic [3:0] q);
    logic [7:0] r;
    case (q)
      4'd0:    r = 8'h8d;
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/aes_block_encrypt_top.sv
// AES-128/192/256 encrypt top: key expansion plus a chain of round cells.
//
//  channel | ports                               | transfer when
//  --------+-------------------------------------+-------------------------
//  input   | start, busy, in_data                | start && !busy
//  result  | out_valid, out_data                 | out_valid (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// One block per cycle while busy is low; the initial AddRoundKey is registered,
// then one round per cell. After reset and after every config write, busy stays
// high for the Nk-word key expansion, a load state and then one word per cycle.
// Results cannot be stalled; each appears for exactly one cycle.
module aes_block_encrypt_top
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  aes_in_t     in_data,
  output logic        out_valid,
  output aes_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [127:0] round_keys [RK_NUM];
  logic [1:0]   key_size_eff;
  logic [3:0]   nr;
  logic         v_r [RK_NUM];
  logic [127:0] s_r [RK_NUM];

  aes_key_exp u_key_exp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .busy         (busy),
    .key_size_eff (key_size_eff),
    .round_keys   (round_keys)
  );

  assign nr = 4'd10 + {1'b0, key_size_eff, 1'b0};

  // initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= start && !busy;
    end
    s_r[0] <= {in_data.plain_high, in_data.plain_low} ^ round_keys[0];
  end

  for (genvar g = 1; g < RK_NUM; g++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.valid = v_r[g-1];
    assign ctl.last  = (nr == 4'(g));
    aes_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (ctl),
      .state_in  (s_r[g-1]),
      .round_key (round_keys[g]),
      .valid_r   (v_r[g]),
      .state_r   (s_r[g])
    );
  end

  assign out_valid = v_r[nr];
  assign out_data  = s_r[nr];

endmodule

// File: rtl/aes_round_cell.sv
// One AES round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round_cell
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cell_ctl_t    ctl_in,
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  output logic         valid_r,
  output logic [127:0] state_r
);

  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [127:0] state_nxt;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = sbox(state_in[127 - 8*(((c + r) % 4)*4 + r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[c*4];
      a1 = sb[c*4+1];
      a2 = sb[c*4+2];
      a3 = sb[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mx[c*4]   = ctl_in.last ? a0 : (a0 ^ all ^ xtime(a0 ^ a1));
      mx[c*4+1] = ctl_in.last ? a1 : (a1 ^ all ^ xtime(a1 ^ a2));
      mx[c*4+2] = ctl_in.last ? a2 : (a2 ^ all ^ xtime(a2 ^ a3));
      mx[c*4+3] = ctl_in.last ? a3 : (a3 ^ all ^ xtime(a3 ^ a0));
    end
    for (int k = 0; k < 16; k++) begin
      state_nxt[127 - 8*k -: 8] = mx[k] ^ round_key[127 - 8*k -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_in.valid;
    end
    state_r <= state_nxt;
  end

endmodule

// File: rtl/aes_key_exp.sv
// Key registers and word-serial FIPS-197 key expansion into round key registers.
module aes_key_exp
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output logic         busy,
  output logic [1:0]   key_size_eff,
  output logic [127:0] round_keys [RK_NUM]
);

  exp_state_t  state_r, state_nxt;
  logic        do_load, do_run;
  logic [1:0]  key_size_r;
  logic [63:0] key_r [4];
  logic [31:0] win_r [8];
  logic [5:0]  i_r;
  logic [2:0]  j_r;
  logic [3:0]  q_r;
  logic [2:0]  nk_m1;
  logic [5:0]  total_m1;
  logic [31:0] new_word, temp, key_word;
  logic        cfg_wr;

  assign key_size_eff = (key_size_r == 2'd3) ? KS_256 : key_size_r;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    case (key_size_eff)
      KS_128:  begin nk_m1 = 3'd3; total_m1 = 6'd43; end
      KS_192:  begin nk_m1 = 3'd5; total_m1 = 6'd51; end
      default: begin nk_m1 = 3'd7; total_m1 = 6'd59; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EXP_LOAD: state_nxt = EXP_RUN;
      EXP_RUN:  if (i_r == total_m1) state_nxt = EXP_IDLE;
      EXP_IDLE: if (cfg_wr) state_nxt = EXP_LOAD;
      default:  state_nxt = EXP_LOAD;
    endcase
  end

  always_comb begin
    do_load   = 1'b0;
    do_run    = 1'b0;
    cfg_ready = 1'b0;
    busy      = 1'b1;
    unique case (state_r)
      EXP_LOAD: do_load = 1'b1;
      EXP_RUN:  do_run = 1'b1;
      EXP_IDLE: begin
        cfg_ready = 1'b1;
        busy      = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    key_word = i_r[0] ? key_r[i_r[2:1]][31:0] : key_r[i_r[2:1]][63:32];
    temp = win_r[0];
    if (j_r == 3'd0) begin
      temp = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon(q_r), 24'h0};
    end else if (nk_m1 == 3'd7 && j_r == 3'd4) begin
      temp = sub_word(win_r[0]);
    end
    if (i_r <= {3'b000, nk_m1}) new_word = key_word;
    else new_word = win_r[nk_m1] ^ temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= EXP_LOAD;
      key_size_r <= KS_128;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_KEY_SIZE: key_size_r <= cfg_data[1:0];
          REG_KEY_0:    key_r[0] <= cfg_data;
          REG_KEY_1:    key_r[1] <= cfg_data;
          REG_KEY_2:    key_r[2] <= cfg_data;
          REG_KEY_3:    key_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      i_r <= '0;
      j_r <= '0;
      q_r <= '0;
      for (int k = 0; k < RK_NUM; k++) round_keys[k] <= '0;
    end else if (do_run) begin
      i_r <= i_r + 6'd1;
      if (j_r == nk_m1) begin
        j_r <= '0;
        q_r <= q_r + 4'd1;
      end else begin
        j_r <= j_r + 3'd1;
      end
      round_keys[i_r[5:2]][127 - 32*i_r[1:0] -: 32] <= new_word;
      win_r[0] <= new_word;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EXP_RUN && i_r == total_m1) |=> state_r == EXP_IDLE)
    else $error("key expansion did not finish");
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("config write did not restart expansion");
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EXP_LOAD |=> (state_r == EXP_RUN && i_r == 6'd0 && j_r == 3'd0))
    else $error("expansion did not start at word zero");

endmodule

// File: dv/tb_aes_block_encrypt_top.sv
// Self-checking testbench for the AES block encrypt top with its own cipher predictor.
`timescale 1ns / 100ps

module tb_aes_block_encrypt_top;
  import aes_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  aes_in_t     in_data = '0;
  logic        out_valid;
  aes_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  aes_block_encrypt_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the key registers and expanded schedule.
  logic [1:0]   key_size_q;
  logic [63:0]  key_word_q [4];
  logic [7:0]   sched [15][16];
  logic [7:0]   sbox_t [256];

  aes_out_t     cipher_q [$];
  int           mismatches;
  int           idle_cycles;
  bit           timed_out;
  int           send_idle_pct;

  initial begin
    // Forward S-box generated from GF(2^8) inverse and the affine map.
    logic [7:0] p, q, x;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
            ^ {q[3:0], q[7:4]};
      sbox_t[p] = x ^ 8'h63;
    end while (p != 8'h01);
    sbox_t[0] = 8'h63;
  end

  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic int round_count();
    return (key_size_q == 2'd0) ? 10 : (key_size_q == 2'd1) ? 12 : 14;
  endfunction

  task automatic rebuild_schedule();
    logic [7:0] w [60][4];
    logic [7:0] t [4];
    logic [7:0] r0, rc;
    int nr, nk, total;
    nr = round_count();
    nk = nr - 6;
    total = 4 * (nr + 1);
    for (int i = 0; i < nk; i++)
      for (int j = 0; j < 4; j++)
        w[i][j] = key_word_q[(i * 4 + j) / 8][63 - 8 * ((i * 4 + j) % 8) -: 8];
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        r0 = t[0];
        t[0] = sbox_t[t[1]] ^ rc;
        t[1] = sbox_t[t[2]];
        t[2] = sbox_t[t[3]];
        t[3] = sbox_t[r0];
        rc = gf_dbl(rc);
      end else if (nk == 8 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sbox_t[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i - nk][j] ^ t[j];
    end
    for (int r = 0; r < 15; r++)
      for (int b = 0; b < 16; b++)
        sched[r][b] = (4 * r + b / 4 < total) ? w[4 * r + b / 4][b % 4] : 8'h00;
  endtask

  function automatic aes_out_t encrypt_block(aes_in_t blk);
    logic [7:0] s [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, all;
    aes_out_t res;
    int nr;
    nr = round_count();
    for (int i = 0; i < 8; i++) begin
      s[i]     = blk.plain_high[63 - 8 * i -: 8] ^ sched[0][i];
      s[8 + i] = blk.plain_low[63 - 8 * i -: 8] ^ sched[0][8 + i];
    end
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++)
          u[c * 4 + rw] = sbox_t[s[((c + rw) % 4) * 4 + rw]];
      if (r != nr)
        for (int c = 0; c < 4; c++) begin
          a0 = u[4 * c]; a1 = u[4 * c + 1]; a2 = u[4 * c + 2]; a3 = u[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          u[4 * c]     = a0 ^ all ^ gf_dbl(a0 ^ a1);
          u[4 * c + 1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          u[4 * c + 2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          u[4 * c + 3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      for (int b = 0; b < 16; b++) s[b] = u[b] ^ sched[r][b];
    end
    for (int i = 0; i < 8; i++) begin
      res.cipher_high[63 - 8 * i -: 8] = s[i];
      res.cipher_low[63 - 8 * i -: 8]  = s[8 + i];
    end
    return res;
  endfunction

  // Result checker and no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          aes_out_t want;
          want = cipher_q.pop_front();
          if (want.cipher_high !== out_data.cipher_high ||
              want.cipher_low !== out_data.cipher_low) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cipher mismatch: exp %h_%h got %h_%h", want.cipher_high,
                       want.cipher_low, out_data.cipher_high, out_data.cipher_low);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KEY_SIZE: key_size_q = (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
      REG_KEY_0:    key_word_q[0] = val;
      REG_KEY_1:    key_word_q[1] = val;
      REG_KEY_2:    key_word_q[2] = val;
      REG_KEY_3:    key_word_q[3] = val;
      default: ;
    endcase
    rebuild_schedule();
    @(posedge clk);
  endtask

  // Raw write to an unmapped index; predictor state is untouched.
  task automatic write_unmapped(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One plaintext block; start held across back-to-back transfers.
  task automatic send_block(aes_in_t blk, bit last);
    start   <= 1'b1;
    in_data <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_q.push_back(encrypt_block(blk));
    if (last || ($urandom_range(99) < send_idle_pct)) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(63);
      3: return ~(64'h1 << $urandom_range(63));
      default: return rand64();
    endcase
  endfunction

  typedef struct {
    aes_in_t  blk;
    bit       known;
    aes_out_t ct;
  } stim_row_t;

  stim_row_t rows [] = '{
    // FIPS-197 C.1 vector needs its key; all-zero key here gives the known
    // zero-key/zero-plaintext ciphertext.
    '{'{64'h0, 64'h0}, 1'b1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}},
    '{'{64'hffffffffffffffff, 64'hffffffffffffffff}, 1'b0, '0},
    '{'{64'h8000000000000000, 64'h0}, 1'b0, '0},
    '{'{64'h0, 64'h0000000000000001}, 1'b0, '0},
    '{'{64'h0011223344556677, 64'h8899aabbccddeeff}, 1'b0, '0},
    '{'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 1'b0, '0}
  };

  aes_in_t fips_pt = '{64'h0011223344556677, 64'h8899aabbccddeeff};

  initial begin
    int phase;
    aes_in_t blk;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    key_size_q = 2'd0;
    for (int i = 0; i < 4; i++) key_word_q[i] = '0;
    #1;
    rebuild_schedule();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_block(rows[i].blk, i == rows.size() - 1);
      if (rows[i].known) cipher_q[cipher_q.size() - 1] = rows[i].ct;
    end
    drain();

    // Standard vectors for each key length.
    write_reg(REG_KEY_0, 64'h0001020304050607);
    write_reg(REG_KEY_1, 64'h08090a0b0c0d0e0f);
    write_reg(REG_KEY_2, 64'h1011121314151617);
    write_reg(REG_KEY_3, 64'h18191a1b1c1d1e1f);
    send_block(fips_pt, 1'b1);
    cipher_q[cipher_q.size() - 1] = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
    drain();
    write_reg(REG_KEY_SIZE, 64'(KS_192));
    send_block(fips_pt, 1'b1);
    cipher_q[cipher_q.size() - 1] = '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191};
    drain();
    write_reg(REG_KEY_SIZE, 64'(KS_256));
    send_block(fips_pt, 1'b1);
    cipher_q[cipher_q.size() - 1] = '{64'h8ea2b7ca516745bf, 64'heafc49904b496089};
    drain();
    // Unused size code saturates to 256; unmapped indexes are ignored.
    write_reg(REG_KEY_SIZE, 64'h3);
    write_unmapped(3'd5, rand64());
    write_unmapped(3'd7, rand64());
    send_block(fips_pt, 1'b1);
    cipher_q[cipher_q.size() - 1] = '{64'h8ea2b7ca516745bf, 64'heafc49904b496089};
    drain();

    for (int k = 0; k < 24; k++) begin
      phase = k / 8;
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 73 : 0;
      if (k % 4 == 0) write_reg(REG_KEY_SIZE, 64'(k % 3));
      else if (k % 4 == 3) write_reg(REG_KEY_SIZE, 64'($urandom & 3));
      write_reg(REG_KEY_0, (k == 5) ? '1 : edge64());
      write_reg(REG_KEY_1, (k == 5) ? '1 : edge64());
      write_reg(REG_KEY_2, (k == 5) ? '1 : edge64());
      write_reg(REG_KEY_3, (k == 5) ? '1 : edge64());
      for (int n = 0; n < 50; n++) begin
        blk.plain_high = ($urandom_range(7) == 0) ? edge64() : rand64();
        blk.plain_low  = ($urandom_range(7) == 0) ? edge64() : rand64();
        send_block(blk, n == 49);
      end
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
